>>> rtl/pcal_pkg.sv
// Shared constants, types and helpers for the calibration table lookup block.
// Used by pcal_div and pa_cal_bilinear_lookup; depends on nothing else.
package pcal_pkg;

	localparam int FREQ_POINTS = 8;
	localparam int TABLE_ROWS  = 8;

	localparam int COL_W   = $clog2(FREQ_POINTS);
	localparam int ROW_W   = $clog2(TABLE_ROWS);
	localparam int DEPTH   = TABLE_ROWS * FREQ_POINTS;
	localparam int ADDR_W  = $clog2(DEPTH);

	localparam int WORD_W  = 16;
	localparam int LEVEL_W = 8;
	localparam int DRIVE_W = 16;

	localparam int FREQ_MIN   = 5650;
	localparam int FREQ_MAX   = 5950;
	localparam int FREQ_RESET = 5800;
	localparam int FREQ_W     = $clog2(FREQ_MAX + 1);
	localparam int ROW_MASK   = 'h7f;

	// Operand and accumulator widths of the interpolation datapath.
	localparam int MUL_W  = 19;
	localparam int PROD_W = 2 * MUL_W;
	localparam int TERM_W = 35;
	localparam int DEN_W  = 34;
	localparam int NUM_W  = 54;
	localparam int SPLIT  = 18;

	localparam int DIV_STEPS = DRIVE_W + 1;
	localparam int DSH_W     = DEN_W + DRIVE_W;

	localparam logic [1:0] REQ_WORD  = 2'd0;
	localparam logic [1:0] REQ_LEVEL = 2'd1;
	localparam logic [1:0] REQ_QUERY = 2'd2;

	localparam logic [1:0] STAT_OK   = 2'd0;
	localparam logic [1:0] STAT_REJ  = 2'd1;
	localparam logic [1:0] STAT_SPAN = 2'd2;

	typedef struct packed {
		logic               done;
		logic [DRIVE_W-1:0] quo;
	} div_res_t;

	function automatic logic [ADDR_W-1:0] cal_addr(input logic [ROW_W-1:0] r,
			input logic [COL_W-1:0] c);
		return ADDR_W'(int'(r) * FREQ_POINTS + int'(c));
	endfunction

endpackage

>>> rtl/pcal_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
// Stand-alone; holds the calibration words of the lookup block.
module pcal_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

>>> rtl/pcal_div.sv
// Restoring divider, one quotient bit per cycle, with saturation to the drive range.
// Depends on pcal_pkg.
module pcal_div (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	input  logic signed [pcal_pkg::NUM_W-1:0] num,
	input  logic signed [pcal_pkg::DEN_W-1:0] den,
	output pcal_pkg::div_res_t              res
);

	localparam int CNT_W = $clog2(pcal_pkg::DIV_STEPS);

	logic                          busy_q;
	logic                          done_q;
	logic [CNT_W-1:0]              cnt_q;
	logic                          neg_q;
	logic [pcal_pkg::NUM_W-1:0]    rem_q;
	logic [pcal_pkg::DSH_W-1:0]    dsh_q;
	logic [pcal_pkg::DIV_STEPS-1:0] q_q;
	logic [pcal_pkg::NUM_W-1:0]    nmag;
	logic [pcal_pkg::DEN_W-1:0]    dmag;
	logic [pcal_pkg::NUM_W:0]      diff;

	assign nmag = num[pcal_pkg::NUM_W-1] ? pcal_pkg::NUM_W'(-num) : pcal_pkg::NUM_W'(num);
	assign dmag = den[pcal_pkg::DEN_W-1] ? pcal_pkg::DEN_W'(-den) : pcal_pkg::DEN_W'(den);
	assign diff = {1'b0, rem_q} - (pcal_pkg::NUM_W + 1)'(dsh_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(pcal_pkg::DIV_STEPS - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= nmag;
			dsh_q <= {dmag, {pcal_pkg::DRIVE_W{1'b0}}};
			neg_q <= num[pcal_pkg::NUM_W-1] ^ den[pcal_pkg::DEN_W-1];
			q_q   <= '0;
		end else if (busy_q) begin
			if (!diff[pcal_pkg::NUM_W]) begin
				rem_q <= diff[pcal_pkg::NUM_W-1:0];
			end
			q_q   <= {q_q[pcal_pkg::DIV_STEPS-2:0], !diff[pcal_pkg::NUM_W]};
			dsh_q <= dsh_q >> 1;
		end
	end

	// The top quotient bit set means the result is at least full scale.
	assign res.done = done_q;
	assign res.quo  = neg_q ? '0 :
		(q_q[pcal_pkg::DIV_STEPS-1] ? '1 : q_q[pcal_pkg::DRIVE_W-1:0]);

	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> $past(busy_q)) else $error("divider done without a run");
	a_no_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> !busy_q) else $error("divider restarted while busy");
	a_busy_count: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q && cnt_q != '0 |=> busy_q) else $error("divider stopped early");

endmodule

>>> rtl/pa_cal_bilinear_lookup.sv
// Top level of the calibration table lookup: sequencer, table storage and shared multiplier.
// Depends on pcal_pkg, pcal_ram and pcal_div.
//
//  channel  direction  handshake            beat contents
//  cfg      in         cfg_we               cfg_wdata (operating frequency, MHz)
//  in       in         in_valid / in_ready  req_type, row_index, column_index, entry_word,
//                                           power_request
//  out      out        out_valid/out_ready  drive_level, status
//
// A write beat goes from idle straight to the result. A query runs a serial grid and
// level search, six table reads, thirteen passes of the one 19x19 multiplier and
// seventeen divider steps. One beat is worked on at a time; in_ready is high only
// while the sequencer is idle, and a finished result waits in the output register.
// Reset clears the row levels and sets the frequency to 5800; table words are undefined
// until written.
module pa_cal_bilinear_lookup (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [15:0]        cfg_wdata,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [1:0]         req_type,
	input  logic [2:0]         row_index,
	input  logic [2:0]         column_index,
	input  logic [15:0]        entry_word,
	input  logic signed [15:0] power_request,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [15:0]        drive_level,
	output logic [1:0]         status
);

	localparam logic [3:0] ST_IDLE  = 4'd0;
	localparam logic [3:0] ST_SRCH  = 4'd1;
	localparam logic [3:0] ST_LOAD  = 4'd2;
	localparam logic [3:0] ST_DIFF  = 4'd3;
	localparam logic [3:0] ST_MUL   = 4'd4;
	localparam logic [3:0] ST_DRAIN = 4'd5;
	localparam logic [3:0] ST_DIVS  = 4'd6;
	localparam logic [3:0] ST_DIVW  = 4'd7;
	localparam logic [3:0] ST_FIN   = 4'd8;

	localparam logic [2:0] OP_NONE = 3'd0;
	localparam logic [2:0] OP_DEN  = 3'd1;
	localparam logic [2:0] OP_P    = 3'd2;
	localparam logic [2:0] OP_LO   = 3'd3;
	localparam logic [2:0] OP_HI   = 3'd4;

	localparam int SRCH_LAST = (pcal_pkg::FREQ_POINTS - 1 > pcal_pkg::TABLE_ROWS - 2) ?
		pcal_pkg::FREQ_POINTS - 1 : pcal_pkg::TABLE_ROWS - 2;
	localparam int LOAD_LAST = 6;
	localparam int KMAX      = (SRCH_LAST > LOAD_LAST) ? SRCH_LAST : LOAD_LAST;
	localparam int CNT_W     = $clog2(KMAX + 1);

	logic [3:0]                      st_q;
	logic [CNT_W-1:0]                k_q;
	logic [1:0]                      c_q;
	logic [2:0]                      nop_q;
	logic [2:0]                      tag_q;
	logic                            fnd_f_q;
	logic                            fnd_l_q;
	logic                            out_valid_q;
	logic [15:0]                     freq_cfg_q;
	logic [pcal_pkg::LEVEL_W-1:0]    lvl_q [pcal_pkg::TABLE_ROWS];

	logic signed [15:0]              power_q;
	logic [pcal_pkg::FREQ_W-1:0]     freq_q;
	logic [pcal_pkg::COL_W-1:0]      col_q;
	logic [pcal_pkg::ROW_W-1:0]      row_q;
	logic [pcal_pkg::LEVEL_W-1:0]    x1_q;
	logic [pcal_pkg::LEVEL_W-1:0]    x2_q;
	logic [pcal_pkg::WORD_W-1:0]     y1_q;
	logic [pcal_pkg::WORD_W-1:0]     y2_q;
	logic [pcal_pkg::WORD_W-1:0]     w_q [4];
	logic signed [16:0]              dx_q;
	logic signed [16:0]              dy_q;
	logic signed [17:0]              a_q [2];
	logic signed [16:0]              b_q [2];
	logic signed [pcal_pkg::PROD_W-1:0] mul_q;
	logic signed [pcal_pkg::TERM_W-1:0] p_q;
	logic signed [pcal_pkg::DEN_W-1:0]  den_q;
	logic signed [pcal_pkg::NUM_W-1:0]  acc_q;
	logic [pcal_pkg::DRIVE_W-1:0]    res_drive_q;
	logic [1:0]                      res_status_q;
	logic [pcal_pkg::DRIVE_W-1:0]    drive_q;
	logic [1:0]                      status_q;

	logic                            accept;
	logic                            fire;
	logic [2:0]                      row_m;
	logic                            bad;
	logic [pcal_pkg::FREQ_W-1:0]     freq_clamp;
	logic                            ram_we;
	logic [pcal_pkg::ADDR_W-1:0]     waddr;
	logic [pcal_pkg::ADDR_W-1:0]     raddr;
	logic [pcal_pkg::WORD_W-1:0]     rd_data;
	logic [pcal_pkg::ROW_W-1:0]      lidx;
	logic [pcal_pkg::LEVEL_W-1:0]    lvl_rd;
	logic                            hit_f;
	logic                            hit_l;
	logic signed [16:0]              dx_d;
	logic signed [16:0]              dy_d;
	logic                            zero_span;
	logic signed [pcal_pkg::MUL_W-1:0]  ma;
	logic signed [pcal_pkg::MUL_W-1:0]  mb;
	logic signed [pcal_pkg::PROD_W-1:0] mprod;
	logic signed [pcal_pkg::NUM_W-1:0]  mul_ext;
	logic                            div_start;
	pcal_pkg::div_res_t              div_res;

	assign in_ready = (st_q == ST_IDLE);
	assign accept   = in_valid && in_ready;
	assign fire     = (st_q == ST_FIN) && (!out_valid_q || out_ready);

	assign row_m = row_index & 3'(pcal_pkg::ROW_MASK);
	assign bad   = (int'(row_m) >= pcal_pkg::TABLE_ROWS)
		|| (req_type == pcal_pkg::REQ_WORD && int'(column_index) >= pcal_pkg::FREQ_POINTS)
		|| (row_m != 3'd0 && 8'(row_m) > lvl_q[0]);

	always_comb begin
		if (int'(freq_cfg_q) < pcal_pkg::FREQ_MIN) begin
			freq_clamp = pcal_pkg::FREQ_W'(pcal_pkg::FREQ_MIN);
		end else if (int'(freq_cfg_q) > pcal_pkg::FREQ_MAX) begin
			freq_clamp = pcal_pkg::FREQ_W'(pcal_pkg::FREQ_MAX);
		end else begin
			freq_clamp = pcal_pkg::FREQ_W'(freq_cfg_q);
		end
	end

	assign ram_we = accept && req_type == pcal_pkg::REQ_WORD && !bad;
	assign waddr  = pcal_pkg::cal_addr(pcal_pkg::ROW_W'(row_m),
		pcal_pkg::COL_W'(column_index));

	always_comb begin
		raddr = '0;
		lidx  = '0;
		if (st_q == ST_SRCH) begin
			raddr = pcal_pkg::cal_addr('0, pcal_pkg::COL_W'(int'(k_q) + 1));
			lidx  = pcal_pkg::ROW_W'(int'(k_q) + 2);
		end else begin
			lidx = (k_q == '0) ? row_q : row_q + 1'b1;
			case (int'(k_q))
				0: raddr = pcal_pkg::cal_addr('0, col_q);
				1: raddr = pcal_pkg::cal_addr('0, col_q + 1'b1);
				2: raddr = pcal_pkg::cal_addr(row_q, col_q);
				3: raddr = pcal_pkg::cal_addr(row_q + 1'b1, col_q);
				4: raddr = pcal_pkg::cal_addr(row_q, col_q + 1'b1);
				5: raddr = pcal_pkg::cal_addr(row_q + 1'b1, col_q + 1'b1);
				default: raddr = '0;
			endcase
		end
	end

	assign lvl_rd = (int'(lidx) < pcal_pkg::TABLE_ROWS) ? lvl_q[lidx] : '0;

	pcal_ram #(
		.WIDTH (pcal_pkg::WORD_W),
		.DEPTH (pcal_pkg::DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (waddr),
		.wdata (entry_word),
		.raddr (raddr),
		.rdata (rd_data)
	);

	// The RAM read port is registered, so step k compares grid column k.
	assign hit_f = (st_q == ST_SRCH) && int'(k_q) >= 1
		&& int'(k_q) <= pcal_pkg::FREQ_POINTS - 1 && !fnd_f_q && 16'(freq_q) < rd_data;
	assign hit_l = (st_q == ST_SRCH) && int'(k_q) <= pcal_pkg::TABLE_ROWS - 3 && !fnd_l_q
		&& $signed({power_q[15], power_q}) < $signed({1'b0, lvl_rd, 8'h00});

	assign dx_d      = $signed({1'b0, x2_q, 8'h00}) - $signed({1'b0, x1_q, 8'h00});
	assign dy_d      = $signed({1'b0, y2_q}) - $signed({1'b0, y1_q});
	assign zero_span = (dx_d == '0) || (dy_d == '0);

	always_comb begin
		ma = '0;
		mb = '0;
		case (nop_q)
			OP_DEN: begin
				ma = {{2{dx_q[16]}}, dx_q};
				mb = {{2{dy_q[16]}}, dy_q};
			end
			OP_P: begin
				ma = {a_q[c_q[0]][17], a_q[c_q[0]]};
				mb = {{2{b_q[c_q[1]][16]}}, b_q[c_q[1]]};
			end
			OP_LO: begin
				ma = {3'b000, w_q[c_q]};
				mb = {1'b0, mul_q[pcal_pkg::SPLIT-1:0]};
			end
			OP_HI: begin
				ma = {3'b000, w_q[c_q]};
				mb = {{2{p_q[pcal_pkg::TERM_W-1]}}, p_q[pcal_pkg::TERM_W-1:pcal_pkg::SPLIT]};
			end
			default: begin
				ma = '0;
				mb = '0;
			end
		endcase
	end

	assign mprod   = ma * mb;
	assign mul_ext = {{(pcal_pkg::NUM_W - pcal_pkg::PROD_W){mul_q[pcal_pkg::PROD_W-1]}}, mul_q};
	assign div_start = (st_q == ST_DIVS);

	pcal_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (acc_q),
		.den    (den_q),
		.res    (div_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= ST_IDLE;
			k_q         <= '0;
			c_q         <= '0;
			nop_q       <= OP_NONE;
			tag_q       <= OP_NONE;
			fnd_f_q     <= 1'b0;
			fnd_l_q     <= 1'b0;
			out_valid_q <= 1'b0;
			freq_cfg_q  <= 16'(pcal_pkg::FREQ_RESET);
			for (int i = 0; i < pcal_pkg::TABLE_ROWS; i++) begin
				lvl_q[i] <= '0;
			end
		end else begin
			if (cfg_we) begin
				freq_cfg_q <= cfg_wdata;
			end
			if (accept && req_type == pcal_pkg::REQ_LEVEL && !bad) begin
				lvl_q[pcal_pkg::ROW_W'(row_m)] <= entry_word[7:0];
			end
			if (fire) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			tag_q <= OP_NONE;
			unique case (st_q)
				ST_IDLE: begin
					if (accept) begin
						k_q     <= '0;
						fnd_f_q <= 1'b0;
						fnd_l_q <= 1'b0;
						st_q    <= (req_type == pcal_pkg::REQ_QUERY) ? ST_SRCH : ST_FIN;
					end
				end
				ST_SRCH: begin
					if (hit_f) fnd_f_q <= 1'b1;
					if (hit_l) fnd_l_q <= 1'b1;
					if (int'(k_q) == SRCH_LAST) begin
						k_q  <= '0;
						st_q <= ST_LOAD;
					end else begin
						k_q <= k_q + 1'b1;
					end
				end
				ST_LOAD: begin
					k_q <= k_q + 1'b1;
					if (int'(k_q) == LOAD_LAST) begin
						st_q <= ST_DIFF;
					end
				end
				ST_DIFF: begin
					c_q   <= '0;
					nop_q <= OP_DEN;
					st_q  <= zero_span ? ST_FIN : ST_MUL;
				end
				ST_MUL: begin
					tag_q <= nop_q;
					unique case (nop_q)
						OP_DEN: nop_q <= OP_P;
						OP_P:   nop_q <= OP_LO;
						OP_LO:  nop_q <= OP_HI;
						default: begin
							nop_q <= OP_P;
							if (c_q == 2'd3) begin
								nop_q <= OP_NONE;
								st_q  <= ST_DRAIN;
							end else begin
								c_q <= c_q + 1'b1;
							end
						end
					endcase
				end
				ST_DRAIN: st_q <= ST_DIVS;
				ST_DIVS:  st_q <= ST_DIVW;
				ST_DIVW: begin
					if (div_res.done) st_q <= ST_FIN;
				end
				ST_FIN: begin
					if (fire) st_q <= ST_IDLE;
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		mul_q <= mprod;
		case (tag_q)
			OP_DEN:  den_q <= mul_q[pcal_pkg::DEN_W-1:0];
			OP_P:    p_q   <= mul_q[pcal_pkg::TERM_W-1:0];
			OP_LO:   acc_q <= acc_q + mul_ext;
			OP_HI:   acc_q <= acc_q + (mul_ext <<< pcal_pkg::SPLIT);
			default: ;
		endcase
		case (st_q)
			ST_IDLE: begin
				if (accept) begin
					power_q      <= power_request;
					freq_q       <= freq_clamp;
					col_q        <= pcal_pkg::COL_W'(pcal_pkg::FREQ_POINTS - 2);
					row_q        <= pcal_pkg::ROW_W'(pcal_pkg::TABLE_ROWS - 2);
					res_drive_q  <= '0;
					res_status_q <= ((req_type == pcal_pkg::REQ_WORD
						|| req_type == pcal_pkg::REQ_LEVEL) && bad) ?
						pcal_pkg::STAT_REJ : pcal_pkg::STAT_OK;
				end
			end
			ST_SRCH: begin
				if (hit_f) col_q <= pcal_pkg::COL_W'(int'(k_q) - 1);
				if (hit_l) row_q <= pcal_pkg::ROW_W'(int'(k_q) + 1);
			end
			ST_LOAD: begin
				if (k_q == '0) x1_q <= lvl_rd;
				if (int'(k_q) == 1) begin
					x2_q <= lvl_rd;
					y1_q <= rd_data;
				end
				if (int'(k_q) == 2) y2_q <= rd_data;
				if (int'(k_q) >= 3) w_q[2'(int'(k_q) - 3)] <= rd_data;
			end
			ST_DIFF: begin
				dx_q   <= dx_d;
				dy_q   <= dy_d;
				a_q[0] <= $signed({2'b00, x2_q, 8'h00}) - $signed({{2{power_q[15]}}, power_q});
				a_q[1] <= $signed({{2{power_q[15]}}, power_q}) - $signed({2'b00, x1_q, 8'h00});
				b_q[0] <= $signed({1'b0, y2_q}) - $signed(17'(freq_q));
				b_q[1] <= $signed(17'(freq_q)) - $signed({1'b0, y1_q});
				acc_q  <= '0;
				if (zero_span) begin
					res_drive_q  <= '0;
					res_status_q <= pcal_pkg::STAT_SPAN;
				end
			end
			ST_DIVW: begin
				if (div_res.done) begin
					res_drive_q  <= div_res.quo;
					res_status_q <= pcal_pkg::STAT_OK;
				end
			end
			ST_FIN: begin
				if (fire) begin
					drive_q  <= res_drive_q;
					status_q <= res_status_q;
				end
			end
			default: ;
		endcase
	end

	assign out_valid   = out_valid_q;
	assign drive_level = drive_q;
	assign status      = status_q;

	a_span_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == pcal_pkg::STAT_SPAN |-> drive_level == '0)
		else $error("zero span result carries a drive value");
	a_rej_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == pcal_pkg::STAT_REJ |-> drive_level == '0)
		else $error("rejected write carries a drive value");
	a_write_fast: assert property (@(posedge clk) disable iff (!arst_n)
		accept && req_type != pcal_pkg::REQ_QUERY |=> st_q == ST_FIN)
		else $error("write beat did not go straight to the result");
	a_div_owner: assert property (@(posedge clk) disable iff (!arst_n)
		div_res.done |-> st_q == ST_DIVW)
		else $error("divider finished outside the divide wait");

endmodule
